FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block's checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/vvi_ptc_pkg.sv
// ---------------------------------------------------------------------------
// VVI pacing timing package
// Shared types, register indexes and default widths for the timing block.
// ---------------------------------------------------------------------------
package vvi_ptc_pkg;

  localparam int TIMER_BITS_DEF = 12;
  localparam int REG_BITS       = 12;
  localparam int IDX_BITS       = 8;
  localparam int IN_DATA_BITS   = 8;
  localparam int OUT_DATA_BITS  = 8;

  localparam logic [REG_BITS-1:0] REG_RESET = 12'd1000;

  localparam logic [IDX_BITS-1:0] REG_LOWER_RATE = 8'd0;
  localparam logic [IDX_BITS-1:0] REG_PACE_WIDTH = 8'd1;
  localparam logic [IDX_BITS-1:0] REG_BLANKING   = 8'd2;
  localparam logic [IDX_BITS-1:0] REG_REFRACTORY = 8'd3;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_PACE  = 2'd1,
    PH_BLANK = 2'd2,
    PH_REFR  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [REG_BITS-1:0] lower_rate_interval;
    logic [REG_BITS-1:0] pace_width;
    logic [REG_BITS-1:0] blanking_interval;
    logic [REG_BITS-1:0] refractory_interval;
  } cfg_t;

  typedef struct packed {
    phase_t phase;
    logic   sensor_enabled;
    logic   pace_on;
  } res_t;

endpackage

FILE: design/vvi_ptc_cfg_regs.sv
// ---------------------------------------------------------------------------
// Configuration registers
// Holds the four interval registers written through the configuration port.
// ---------------------------------------------------------------------------
module vvi_ptc_cfg_regs
  import vvi_ptc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [IDX_BITS-1:0] wr_index,
  input  logic [REG_BITS-1:0] wr_data,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_LOWER_RATE: cfg_nxt.lower_rate_interval = wr_data;
        REG_PACE_WIDTH: cfg_nxt.pace_width          = wr_data;
        REG_BLANKING:   cfg_nxt.blanking_interval   = wr_data;
        REG_REFRACTORY: cfg_nxt.refractory_interval = wr_data;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{REG_RESET, REG_RESET, REG_RESET, REG_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: design/vvi_ptc_in_reg.sv
// ---------------------------------------------------------------------------
// Input register
// Captures one tick request and holds it until the timing core takes it.
// ---------------------------------------------------------------------------
module vvi_ptc_in_reg
  import vvi_ptc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_sensed,
  output logic s1_valid,
  output logic s1_sensed,
  input  logic s1_take
);

  logic valid_r;
  logic valid_nxt;
  logic sensed_r;

  assign in_ready  = !valid_r || s1_take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sensed_r <= in_sensed;
    end
  end

  assign s1_valid  = valid_r;
  assign s1_sensed = sensed_r;

endmodule

FILE: design/vvi_ptc_core.sv
// ---------------------------------------------------------------------------
// Timing core
// Phase state machine with the lower-rate and phase countdowns.
// ---------------------------------------------------------------------------
module vvi_ptc_core
  import vvi_ptc_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic advance,
  input  logic sensed,
  input  cfg_t cfg,
  output res_t res_nxt
);

  localparam int WB = (TIMER_BITS > REG_BITS) ? TIMER_BITS : REG_BITS;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  function automatic logic [TIMER_BITS-1:0] load_value(input logic [REG_BITS-1:0] v);
    logic [WB-1:0] w;
    w = WB'(v);
    if (w > WB'(TIMER_MAX)) begin
      load_value = TIMER_MAX;
    end else begin
      load_value = TIMER_BITS'(w);
    end
  endfunction

  phase_t                phase_r;
  phase_t                phase_nxt;
  logic [TIMER_BITS-1:0] lr_r;
  logic [TIMER_BITS-1:0] lr_nxt;
  logic [TIMER_BITS-1:0] ph_r;
  logic [TIMER_BITS-1:0] ph_nxt;
  logic                  pace_r;
  logic                  pace_nxt;
  logic                  sensor_r;
  logic                  sensor_nxt;
  logic [TIMER_BITS-1:0] lr_dec;
  logic [TIMER_BITS-1:0] ph_dec;

  assign lr_dec = (lr_r == '0) ? '0 : lr_r - TIMER_BITS'(1);
  assign ph_dec = (ph_r == '0) ? '0 : ph_r - TIMER_BITS'(1);

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_WAIT: begin
        if (lr_dec == '0) begin
          phase_nxt = PH_PACE;
        end else if (sensed) begin
          phase_nxt = PH_BLANK;
        end
      end
      PH_PACE: begin
        if (ph_dec == '0) phase_nxt = PH_BLANK;
      end
      PH_BLANK: begin
        if (ph_dec == '0) phase_nxt = PH_REFR;
      end
      PH_REFR: begin
        if (ph_dec == '0) phase_nxt = PH_WAIT;
      end
    endcase
  end

  always_comb begin
    lr_nxt     = lr_dec;
    ph_nxt     = ph_dec;
    pace_nxt   = pace_r;
    sensor_nxt = sensor_r;
    unique case (phase_r)
      PH_WAIT: begin
        if (phase_nxt == PH_PACE) begin
          lr_nxt     = load_value(cfg.lower_rate_interval);
          ph_nxt     = load_value(cfg.pace_width);
          pace_nxt   = 1'b1;
          sensor_nxt = 1'b0;
        end else if (phase_nxt == PH_BLANK) begin
          lr_nxt     = load_value(cfg.lower_rate_interval);
          ph_nxt     = load_value(cfg.blanking_interval);
          sensor_nxt = 1'b0;
        end
      end
      PH_PACE: begin
        if (phase_nxt == PH_BLANK) begin
          pace_nxt = 1'b0;
          ph_nxt   = load_value(cfg.blanking_interval);
        end
      end
      PH_BLANK: begin
        if (phase_nxt == PH_REFR) begin
          sensor_nxt = 1'b1;
          ph_nxt     = load_value(cfg.refractory_interval);
        end
      end
      PH_REFR: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      lr_r     <= load_value(REG_RESET);
      ph_r     <= '0;
      pace_r   <= 1'b0;
      sensor_r <= 1'b1;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      lr_r     <= lr_nxt;
      ph_r     <= ph_nxt;
      pace_r   <= pace_nxt;
      sensor_r <= sensor_nxt;
    end
  end

  assign res_nxt.phase          = phase_nxt;
  assign res_nxt.sensor_enabled = sensor_nxt;
  assign res_nxt.pace_on        = pace_nxt;

endmodule

FILE: design/vvi_ptc_out_reg.sv
// ---------------------------------------------------------------------------
// Result register
// Holds one result until the downstream side takes it.
// ---------------------------------------------------------------------------
module vvi_ptc_out_reg
  import vvi_ptc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res_in,
  output logic out_valid,
  input  logic out_ready,
  output logic can_load,
  output res_t res_out
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

FILE: design/vvi_pacing_timing_controller.sv
// Flow: a tick waits in the input register, its result in the result register.
// Throughput: one tick per cycle while results are taken; the phase update is
// a single pass of the core. Reset: synchronous, active low; phase waiting,
// lower-rate countdown loaded from the default interval, pace off, sensor
// enabled, the four interval registers at 1000.
// ---------------------------------------------------------------------------
// VVI pacing timing controller
// Input register, timing core and result register with a configuration port.
// ---------------------------------------------------------------------------
module vvi_pacing_timing_controller
  import vvi_ptc_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // [0] sensed, [7:1] zero
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // [0] pace_on, [1] sensor_enabled, [3:2] phase, [7:4] zero
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_BITS-1:0]      cfg_index,
  input  logic [REG_BITS-1:0]      cfg_data
);

  cfg_t cfg;
  res_t res_nxt;
  res_t res_q;
  logic s1_valid;
  logic s1_sensed;
  logic can_load;
  logic advance;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && can_load;

  vvi_ptc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  vvi_ptc_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sensed (in_tdata[0]),
    .s1_valid  (s1_valid),
    .s1_sensed (s1_sensed),
    .s1_take   (advance)
  );

  vvi_ptc_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .sensed  (s1_sensed),
    .cfg     (cfg),
    .res_nxt (res_nxt)
  );

  vvi_ptc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_in    (res_nxt),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .can_load  (can_load),
    .res_out   (res_q)
  );

  assign out_tdata = {4'b0000, res_q.phase, res_q.sensor_enabled, res_q.pace_on};

endmodule

FILE: design/vvi_ptc_checker.sv
// ---------------------------------------------------------------------------
// Port checker
// Checks phase, pace and sensor consistency and stall hold on the results.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vvi_ptc_checker
  import vvi_ptc_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata
);

  logic [1:0] ph;
  logic       sens;
  logic       pace_v;
  logic       shield_v;
  logic       open_v;
  logic       stall_v;

  assign ph       = out_tdata[3:2];
  assign sens     = out_tdata[1];
  assign pace_v   = out_tvalid && out_tdata[0];
  assign shield_v = out_tvalid && (ph == PH_PACE || ph == PH_BLANK);
  assign open_v   = out_tvalid && (ph == PH_WAIT || ph == PH_REFR);
  assign stall_v  = out_tvalid && !out_tready;

  `ASSERT_IMPLIES(a_pace_phase, clk, rst_n, pace_v, ph == PH_PACE, "Pace outside pacing.")
  `ASSERT_IMPLIES(a_sensor_off, clk, rst_n, shield_v, !sens, "Sensor on while protected.")
  `ASSERT_IMPLIES(a_sensor_on, clk, rst_n, open_v, sens, "Sensor off while unprotected.")
  `ASSERT_NEXT(a_stall_valid, clk, rst_n, stall_v, out_tvalid, "Stalled result dropped.")
  `ASSERT_NEXT(a_stall_data, clk, rst_n, stall_v, $stable(out_tdata), "Stalled result changed.")

endmodule

bind vvi_pacing_timing_controller vvi_ptc_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// VVI pacing timing controller testbench
// Sends millisecond tick requests with a ventricular sense flag, tracks the
// pacing phases, both countdowns and the four timing registers in a local
// model, and checks every result against it. Both stream sides idle at
// random, and one long receiver hold-off backs the block up.
// ---------------------------------------------------------------------------
module testbench;
  import vvi_ptc_pkg::*;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PIPE_SLACK      = 6;
  localparam int REPORT_LIMIT    = 150;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [IDX_BITS-1:0]      cfg_index;
  logic [REG_BITS-1:0]      cfg_data;

  // Timing registers and state as the block should hold them.
  logic [REG_BITS-1:0]       lower_rate_ivl = REG_RESET;
  logic [REG_BITS-1:0]       pace_width_ivl = REG_RESET;
  logic [REG_BITS-1:0]       blanking_ivl   = REG_RESET;
  logic [REG_BITS-1:0]       refractory_ivl = REG_RESET;
  logic [TIMER_BITS_DEF-1:0] rate_left      = REG_RESET;
  logic [TIMER_BITS_DEF-1:0] phase_left     = '0;
  phase_t                    cur_phase      = PH_WAIT;
  logic                      pace_drv       = 1'b0;
  logic                      sense_en       = 1'b1;

  res_t expected_beats[$];
  int   mismatches     = 0;
  int   idle_cycles    = 0;
  bit   steady         = 1'b0;
  bit   hold_off_req   = 1'b0;

  vvi_pacing_timing_controller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [REG_BITS-1:0] pick_interval(input int limit);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return REG_BITS'(1);
    return REG_BITS'($urandom_range(1, limit));
  endfunction

  // Advances the local timing state by one tick and queues the result.
  task automatic tick_timing(input logic sensed);
    res_t want;
    rate_left  = (rate_left == 0) ? '0 : rate_left - TIMER_BITS_DEF'(1);
    phase_left = (phase_left == 0) ? '0 : phase_left - TIMER_BITS_DEF'(1);
    case (cur_phase)
      PH_WAIT: begin
        if (rate_left == 0) begin
          rate_left  = lower_rate_ivl;
          phase_left = pace_width_ivl;
          pace_drv   = 1'b1;
          sense_en   = 1'b0;
          cur_phase  = PH_PACE;
        end else if (sensed) begin
          rate_left  = lower_rate_ivl;
          phase_left = blanking_ivl;
          sense_en   = 1'b0;
          cur_phase  = PH_BLANK;
        end
      end
      PH_PACE: begin
        if (phase_left == 0) begin
          pace_drv   = 1'b0;
          phase_left = blanking_ivl;
          cur_phase  = PH_BLANK;
        end
      end
      PH_BLANK: begin
        if (phase_left == 0) begin
          sense_en   = 1'b1;
          phase_left = refractory_ivl;
          cur_phase  = PH_REFR;
        end
      end
      default: begin
        if (phase_left == 0) cur_phase = PH_WAIT;
      end
    endcase
    want.pace_on        = pace_drv;
    want.sensor_enabled = sense_en;
    want.phase          = cur_phase;
    expected_beats.push_back(want);
  endtask

  task automatic send_tick(input logic sensed);
    int gap;
    gap = steady ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_BITS-1){1'b0}}, sensed};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tick_timing(sensed);
  endtask

  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LOWER_RATE: lower_rate_ivl = value;
      REG_PACE_WIDTH: pace_width_ivl = value;
      REG_BLANKING:   blanking_ivl   = value;
      REG_REFRACTORY: refractory_ivl = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops offering ticks and waits until every result has come back.
  task automatic settle_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // Zero intervals expire on the next tick; also covers sensing outside
  // waiting and pacing taking priority over a sensed beat.
  task automatic test_zero_intervals();
    settle_idle();
    write_reg(REG_LOWER_RATE, '0);
    write_reg(REG_PACE_WIDTH, '0);
    write_reg(REG_BLANKING, '0);
    write_reg(REG_REFRACTORY, '0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  task automatic test_unknown_index();
    settle_idle();
    write_reg(IDX_BITS'(4), REG_BITS'(5));
    write_reg({IDX_BITS{1'b1}}, {REG_BITS{1'b1}});
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  task automatic test_random_ticks();
    int sense_pct;
    for (int p = 0; p < 6; p++) begin
      settle_idle();
      if (p == 0 || $urandom_range(0, 3) != 0) write_reg(REG_LOWER_RATE, pick_interval(40));
      if (p == 0 || $urandom_range(0, 3) != 0) write_reg(REG_PACE_WIDTH, pick_interval(10));
      if (p == 0 || $urandom_range(0, 3) != 0) write_reg(REG_BLANKING, pick_interval(10));
      if (p == 0 || $urandom_range(0, 3) != 0) write_reg(REG_REFRACTORY, pick_interval(10));
      sense_pct = $urandom_range(0, 60);
      for (int n = 0; n < 65; n++) begin
        if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        send_tick($urandom_range(0, 99) < sense_pct);
      end
    end
    steady = 1'b0;
  endtask

  // The receiver holds off while ticks keep coming, so the input stalls.
  task automatic test_backpressure();
    settle_idle();
    write_reg(REG_LOWER_RATE, REG_BITS'(9));
    write_reg(REG_PACE_WIDTH, REG_BITS'(2));
    write_reg(REG_BLANKING, REG_BITS'(3));
    write_reg(REG_REFRACTORY, REG_BITS'(2));
    steady       = 1'b1;
    hold_off_req = 1'b1;
    for (int n = 0; n < 40; n++) send_tick($urandom_range(0, 4) == 0);
    steady = 1'b0;
  endtask

  task automatic test_max_intervals();
    settle_idle();
    write_reg(REG_LOWER_RATE, {REG_BITS{1'b1}});
    write_reg(REG_PACE_WIDTH, REG_BITS'(2));
    write_reg(REG_BLANKING, REG_BITS'(2));
    write_reg(REG_REFRACTORY, REG_BITS'(2));
    for (int n = 0; n < 10; n++) send_tick(n % 3 == 0);
    settle_idle();
    write_reg(REG_PACE_WIDTH, {REG_BITS{1'b1}});
    write_reg(REG_BLANKING, {REG_BITS{1'b1}});
    write_reg(REG_REFRACTORY, {REG_BITS{1'b1}});
    send_tick(1'b1);
    send_tick(1'b1);
  endtask

  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = steady ? 0 : idle_len();
      if (hold_off_req) begin
        stall        = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : beat_check
    res_t want;
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[3:0]);
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $error("result with no request pending: %h", out_tdata);
      end else begin
        want = expected_beats.pop_front();
        if (got.pace_on !== want.pace_on) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $error("pace_on: expected %0d, got %0d", want.pace_on, got.pace_on);
        end
        if (got.sensor_enabled !== want.sensor_enabled) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $error("sensor_enabled: expected %0d, got %0d",
                   want.sensor_enabled, got.sensor_enabled);
        end
        if (got.phase !== want.phase) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $error("phase: expected %0d, got %0d", want.phase, got.phase);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** vvi_pacing_timing_controller: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_zero_intervals();
    test_unknown_index();
    test_random_ticks();
    test_backpressure();
    test_max_intervals();
    settle_idle();

    if (mismatches == 0) begin
      $display("** vvi_pacing_timing_controller: PASSED **");
    end else begin
      $display("** vvi_pacing_timing_controller: FAILED **");
    end
    $finish;
  end

endmodule
